// ===== rtl/hsi_pkg.sv =====
// ----------------------------------------------------------------------------
// hsi_pkg
// Types, constants and constant tables shared by the HSI to RGB converter.
// ----------------------------------------------------------------------------
`default_nettype none

package hsi_pkg;

  localparam int FRAC_BITS       = 15;
  localparam int COS_TABLE_DEPTH = 1024;

  localparam longint PI_Q28      = 64'sd843314857;
  localparam longint Q28_UNIT    = 64'sd268435456;
  localparam int     SERIES_TERMS = 15;

  // (2n-1)*(2n) for series term n
  localparam longint SERIES_DIV [1:SERIES_TERMS-1] = '{
    2, 12, 30, 56, 90, 132, 182, 240, 306, 380, 462, 552, 650, 756
  };

  localparam int HUE_W  = 12;
  localparam int SAT_W  = 10;
  localparam int INT_W  = 8;
  localparam int OUT_W  = 16;

  localparam int HUE_WRAP   = 3600;
  localparam int SECTOR_SPAN = 1200;
  localparam int HALF_SPAN  = 600;
  localparam int SAT_MAX    = 1000;

  localparam int OFF_W  = 11;
  localparam int DIFF_W = 11;
  localparam int COS_W  = 22;

  localparam int SH_W   = FRAC_BITS + 1;
  localparam int Q_W    = FRAC_BITS + 2;
  localparam int NUM_W  = 34;
  localparam int DEN_W  = 32;
  localparam int REM_W  = DEN_W + Q_W - 1;

  localparam logic [SH_W-1:0] ONE = SH_W'(1) << FRAC_BITS;

  typedef enum logic [1:0] {
    SECT_RG = 2'd0,
    SECT_GB = 2'd1,
    SECT_BR = 2'd2
  } sector_t;

  typedef logic signed [COS_W-1:0] cos_t;
  typedef cos_t cos_tab_t [0:SECTOR_SPAN];
  typedef logic [SH_W-1:0] xs_tab_t [0:SAT_MAX];

  typedef struct packed {
    logic [REM_W-1:0] rem;
    logic [REM_W-1:0] dsh;
    logic [Q_W-1:0]   q;
    logic [SH_W-1:0]  xs;
    sector_t          sector;
    logic             zero;
  } div_t;

  function automatic longint cos_q20(input longint k);
    longint th;
    longint th2;
    longint term;
    longint sum;
    th   = (k * PI_Q28 + longint'(COS_TABLE_DEPTH / 2)) / COS_TABLE_DEPTH;
    th2  = (th * th) / Q28_UNIT;
    term = Q28_UNIT;
    sum  = Q28_UNIT;
    for (int n = 1; n < SERIES_TERMS; n++) begin
      term = -((term * th2) / Q28_UNIT) / SERIES_DIV[n];
      sum  = sum + term;
    end
    if (sum >= 0) begin
      return (sum + 128) / 256;
    end
    return -((-sum + 128) / 256);
  endfunction

  function automatic cos_tab_t build_cos_tab();
    cos_tab_t tab;
    longint   k;
    for (int t = 0; t <= SECTOR_SPAN; t++) begin
      k      = (longint'(t) * longint'(COS_TABLE_DEPTH) + 900) / 1800;
      tab[t] = COS_W'(cos_q20(k));
    end
    return tab;
  endfunction

  function automatic xs_tab_t build_xs_tab();
    xs_tab_t tab;
    longint  v;
    for (int s = 0; s <= SAT_MAX; s++) begin
      v = (longint'(SAT_MAX - s) * (longint'(1) <<< FRAC_BITS) + 1500) / 3000;
      if (v > (longint'(1) <<< FRAC_BITS)) begin
        v = longint'(1) <<< FRAC_BITS;
      end
      tab[s] = SH_W'(v);
    end
    return tab;
  endfunction

  localparam cos_tab_t COS_TAB = build_cos_tab();
  localparam xs_tab_t  XS_TAB  = build_xs_tab();

endpackage

`default_nettype wire

// ===== rtl/hsi_if.sv =====
// ----------------------------------------------------------------------------
// hsi_in_if / hsi_out_if
// Valid/ready channels for HSI items in and RGB items out.
// ----------------------------------------------------------------------------
`default_nettype none

interface hsi_in_if;
  logic                       valid;
  logic                       ready;
  logic [hsi_pkg::HUE_W-1:0]  hue_tenths;
  logic [hsi_pkg::SAT_W-1:0]  saturation_permille;
  logic [hsi_pkg::INT_W-1:0]  intensity;
  modport source (output valid, hue_tenths, saturation_permille, intensity, input ready);
  modport sink   (input valid, hue_tenths, saturation_permille, intensity, output ready);
endinterface

interface hsi_out_if;
  logic                       valid;
  logic                       ready;
  logic [hsi_pkg::OUT_W-1:0]  red_out;
  logic [hsi_pkg::OUT_W-1:0]  green_out;
  logic [hsi_pkg::OUT_W-1:0]  blue_out;
  logic                       zero_intensity;
  modport source (output valid, red_out, green_out, blue_out, zero_intensity, input ready);
  modport sink   (input valid, red_out, green_out, blue_out, zero_intensity, output ready);
endinterface

`default_nettype wire

// ===== rtl/hsi_front.sv =====
// ----------------------------------------------------------------------------
// hsi_front
// Sector split, cosine and share lookups, dividend and divisor setup.
// ----------------------------------------------------------------------------
`default_nettype none

module hsi_front (
  input  wire logic         clk,
  input  wire logic         rst,
  hsi_in_if.sink            pix_in,
  output hsi_pkg::div_t     out_data,
  output logic              out_valid,
  input  wire logic         out_ready
);

  logic                          v0, v1, v2;
  logic                          en0, en1, en2;
  logic [hsi_pkg::OFF_W-1:0]     off0;
  logic [hsi_pkg::DIFF_W-1:0]    diff0;
  logic [hsi_pkg::SAT_W-1:0]     sat0, sat1;
  hsi_pkg::sector_t              sect0, sect1;
  logic                          zero0, zero1;
  hsi_pkg::cos_t                 ch1, cd1;
  logic [hsi_pkg::SH_W-1:0]      xs1;

  logic [hsi_pkg::HUE_W-1:0]     hue_w;
  logic [hsi_pkg::SAT_W-1:0]     sat_c;
  hsi_pkg::sector_t              sect_c;
  logic [hsi_pkg::HUE_W-1:0]     off_c;
  logic [hsi_pkg::HUE_W-1:0]     diff_c;

  hsi_pkg::cos_t                 cdp;
  logic signed [hsi_pkg::NUM_W-1:0] num;
  logic signed [hsi_pkg::NUM_W-1:0] den_s;
  logic [hsi_pkg::DEN_W-1:0]     den;
  logic [hsi_pkg::REM_W-1:0]     dividend;

  assign en2       = !v2 || out_ready;
  assign en1       = !v1 || en2;
  assign en0       = !v0 || en1;
  assign pix_in.ready = en0;
  assign out_valid = v2;

  always_comb begin
    hue_w = (pix_in.hue_tenths >= hsi_pkg::HUE_W'(hsi_pkg::HUE_WRAP))
          ? pix_in.hue_tenths - hsi_pkg::HUE_W'(hsi_pkg::HUE_WRAP) : pix_in.hue_tenths;
    sat_c = (pix_in.saturation_permille > hsi_pkg::SAT_W'(hsi_pkg::SAT_MAX))
          ? hsi_pkg::SAT_W'(hsi_pkg::SAT_MAX) : pix_in.saturation_permille;
    if (hue_w < hsi_pkg::HUE_W'(hsi_pkg::SECTOR_SPAN)) begin
      sect_c = hsi_pkg::SECT_RG;
      off_c  = hue_w;
    end else if (hue_w < hsi_pkg::HUE_W'(2 * hsi_pkg::SECTOR_SPAN)) begin
      sect_c = hsi_pkg::SECT_GB;
      off_c  = hue_w - hsi_pkg::HUE_W'(hsi_pkg::SECTOR_SPAN);
    end else begin
      sect_c = hsi_pkg::SECT_BR;
      off_c  = hue_w - hsi_pkg::HUE_W'(2 * hsi_pkg::SECTOR_SPAN);
    end
    diff_c = (off_c <= hsi_pkg::HUE_W'(hsi_pkg::HALF_SPAN))
           ? hsi_pkg::HUE_W'(hsi_pkg::HALF_SPAN) - off_c
           : off_c - hsi_pkg::HUE_W'(hsi_pkg::HALF_SPAN);
  end

  always_comb begin
    cdp   = (cd1 <= 0) ? hsi_pkg::COS_W'(1) : cd1;
    num   = hsi_pkg::NUM_W'(cdp) * hsi_pkg::NUM_W'(1000)
          + $signed({{(hsi_pkg::NUM_W-hsi_pkg::SAT_W){1'b0}}, sat1}) * hsi_pkg::NUM_W'(ch1);
    den_s = hsi_pkg::NUM_W'(cdp) * hsi_pkg::NUM_W'(3000);
    den   = den_s[hsi_pkg::DEN_W-1:0];
    if (num > 0) begin
      dividend = (hsi_pkg::REM_W'(num[hsi_pkg::NUM_W-2:0]) << hsi_pkg::FRAC_BITS)
               + hsi_pkg::REM_W'(den >> 1);
    end else begin
      dividend = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      if (en0) v0 <= pix_in.valid;
      if (en1) v1 <= v0;
      if (en2) v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en0) begin
      off0  <= off_c[hsi_pkg::OFF_W-1:0];
      diff0 <= diff_c[hsi_pkg::DIFF_W-1:0];
      sat0  <= sat_c;
      sect0 <= sect_c;
      zero0 <= (pix_in.intensity == '0);
    end
    if (en1) begin
      ch1   <= hsi_pkg::COS_TAB[off0];
      cd1   <= hsi_pkg::COS_TAB[diff0];
      xs1   <= hsi_pkg::XS_TAB[sat0];
      sat1  <= sat0;
      sect1 <= sect0;
      zero1 <= zero0;
    end
    if (en2) begin
      out_data.rem    <= dividend;
      out_data.dsh    <= hsi_pkg::REM_W'(den) << (hsi_pkg::Q_W - 1);
      out_data.q      <= '0;
      out_data.xs     <= xs1;
      out_data.sector <= sect1;
      out_data.zero   <= zero1;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/hsi_div_cell.sv =====
// ----------------------------------------------------------------------------
// hsi_div_cell
// One restoring divide step: compare, subtract, shift divisor, take a bit.
// ----------------------------------------------------------------------------
`default_nettype none

module hsi_div_cell (
  input  wire logic          clk,
  input  wire logic          rst,
  input  hsi_pkg::div_t      in_data,
  input  wire logic          in_valid,
  output logic               in_ready,
  output hsi_pkg::div_t      out_data,
  output logic               out_valid,
  input  wire logic          out_ready
);

  logic take;

  assign in_ready = !out_valid || out_ready;
  assign take     = in_data.rem >= in_data.dsh;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready) begin
      out_data     <= in_data;
      out_data.rem <= take ? in_data.rem - in_data.dsh : in_data.rem;
      out_data.dsh <= in_data.dsh >> 1;
      out_data.q   <= {in_data.q[hsi_pkg::Q_W-2:0], take};
    end
  end

endmodule

`default_nettype wire

// ===== rtl/hsi_back.sv =====
// ----------------------------------------------------------------------------
// hsi_back
// Clamp shares, route them to channels by sector, hold the result item.
// ----------------------------------------------------------------------------
`default_nettype none

module hsi_back (
  input  wire logic          clk,
  input  wire logic          rst,
  input  hsi_pkg::div_t      in_data,
  input  wire logic          in_valid,
  output logic               in_ready,
  hsi_out_if.source          pix_out
);

  logic [hsi_pkg::SH_W-1:0]    ys, zs, r, g, b;
  logic signed [hsi_pkg::SH_W+2:0] zt;
  logic [hsi_pkg::SH_W+hsi_pkg::OUT_W-1:0] re, ge, be;

  assign in_ready = !pix_out.valid || pix_out.ready;

  always_comb begin
    ys = (in_data.q > hsi_pkg::Q_W'(hsi_pkg::ONE)) ? hsi_pkg::ONE
                                                   : in_data.q[hsi_pkg::SH_W-1:0];
    zt = $signed({3'b000, hsi_pkg::ONE}) - $signed({3'b000, in_data.xs})
       - $signed({3'b000, ys});
    if (zt < 0) begin
      zs = '0;
    end else if (zt > $signed({3'b000, hsi_pkg::ONE})) begin
      zs = hsi_pkg::ONE;
    end else begin
      zs = zt[hsi_pkg::SH_W-1:0];
    end
    case (in_data.sector)
      hsi_pkg::SECT_RG: begin b = in_data.xs; r = ys; g = zs; end
      hsi_pkg::SECT_GB: begin r = in_data.xs; g = ys; b = zs; end
      default:          begin g = in_data.xs; b = ys; r = zs; end
    endcase
    if (in_data.zero) begin
      r = '0;
      g = '0;
      b = '0;
    end
    re = {{hsi_pkg::OUT_W{1'b0}}, r};
    ge = {{hsi_pkg::OUT_W{1'b0}}, g};
    be = {{hsi_pkg::OUT_W{1'b0}}, b};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pix_out.valid <= 1'b0;
    end else if (in_ready) begin
      pix_out.valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready) begin
      pix_out.red_out        <= re[hsi_pkg::OUT_W-1:0];
      pix_out.green_out      <= ge[hsi_pkg::OUT_W-1:0];
      pix_out.blue_out       <= be[hsi_pkg::OUT_W-1:0];
      pix_out.zero_intensity <= in_data.zero;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/hsi_to_rgb_converter.sv =====
// ----------------------------------------------------------------------------
// hsi_to_rgb_converter
// HSI to normalized RGB shares, one item per clock through a divider chain while pix_out is not stalled.
// ----------------------------------------------------------------------------
// channel   role    payload
// pix_in    sink    hue_tenths, saturation_permille, intensity
// pix_out   source  red_out, green_out, blue_out, zero_intensity
//
// One item per clock sustained while pix_out is not stalled; three setup stages,
// one cell per quotient bit (17 cells), one output register.
// Each stage holds its item only while the stage after it is full and stalled,
// so bubbles close up under output backpressure.
// Reset clears the stage valid bits only.
// ----------------------------------------------------------------------------
`default_nettype none

module hsi_to_rgb_converter (
  input  wire logic   clk,
  input  wire logic   rst,
  hsi_in_if.sink      pix_in,
  hsi_out_if.source   pix_out
);

  hsi_pkg::div_t chain [0:hsi_pkg::Q_W];
  logic          cv    [0:hsi_pkg::Q_W];
  logic          cr    [0:hsi_pkg::Q_W];

  hsi_front u_front (
    .clk       (clk),
    .rst       (rst),
    .pix_in    (pix_in),
    .out_data  (chain[0]),
    .out_valid (cv[0]),
    .out_ready (cr[0])
  );

  for (genvar i = 0; i < hsi_pkg::Q_W; i++) begin : g_cell
    hsi_div_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .in_data   (chain[i]),
      .in_valid  (cv[i]),
      .in_ready  (cr[i]),
      .out_data  (chain[i+1]),
      .out_valid (cv[i+1]),
      .out_ready (cr[i+1])
    );
  end

  hsi_back u_back (
    .clk      (clk),
    .rst      (rst),
    .in_data  (chain[hsi_pkg::Q_W]),
    .in_valid (cv[hsi_pkg::Q_W]),
    .in_ready (cr[hsi_pkg::Q_W]),
    .pix_out  (pix_out)
  );

endmodule

`default_nettype wire
